FILE: sv/pgm_pkg.sv
`default_nettype none
package pgm_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC_P = 3'd0,
    PH_MAGIC_2 = 3'd1,
    PH_WIDTH   = 3'd2,
    PH_HEIGHT  = 3'd3,
    PH_MAXVAL  = 3'd4,
    PH_PIXEL   = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_BAD_MAGIC  = 3'd1,
    STAT_BAD_SIZE   = 3'd2,
    STAT_BAD_MAXVAL = 3'd3,
    STAT_BAD_PIXEL  = 3'd4,
    STAT_COUNT      = 3'd5,
    STAT_FLAT       = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    CTL_RUN,
    CTL_TOKEN,
    CTL_HEADER,
    CTL_CHECK,
    CTL_DIVIDE,
    CTL_LOAD
  } ctl_e;

  typedef struct packed {
    logic stop;
    logic bad;
    logic digit;
    logic neg;
    logic active;
  } tok_flags_t;

  typedef struct packed {
    logic byte_en;
    logic end_tok;
    logic hdr_chk;
    logic cnt_chk;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_full;
  } dp_stat_t;

  localparam int BYTE_W      = 8;
  localparam int PIX_W       = 9;
  localparam int COUNT_W     = 33;
  localparam int SUM_W       = 41;
  localparam int STATUS_W    = 3;
  localparam int OUT_DIM_W   = 16;
  localparam int OUT_COUNT_W = 32;
  localparam int QUO_W       = 9;
  localparam int DIV_CNT_W   = 4;
  localparam int OUT_DATA_W  = 104;

  localparam logic [PIX_W-1:0] MAXVAL_LIMIT = 9'd256;

  localparam logic [BYTE_W-1:0] CHAR_P     = 8'h50;
  localparam logic [BYTE_W-1:0] CHAR_2     = 8'h32;
  localparam logic [BYTE_W-1:0] CHAR_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2b;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CHAR_VT    = 8'h0b;
  localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0c;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

endpackage
`default_nettype wire

FILE: sv/pgm_ascii_parse_validate_stats.sv
// ascii grey-map (p2) parser, checker and statistics unit
// input stream: one byte of file text per request on s_axis, tdata = data_byte,
//   tlast = end_of_file marks the final byte of a file
// output stream: one result per file on m_axis, produced only for the tlast byte
// throughput: one byte per cycle while a file is being parsed; the whole
//   per-byte token scan and value check is combinational
// after the tlast byte s_axis_tready_o stays low through token close, header
//   check, pixel count compare, a 9-step restoring divider for the mean and
//   the write of the result to the output register
// result: m_axis_tvalid_o rises once the result is loaded; no byte of the
//   next file is taken before that load
// the output register holds the result until taken; the next file is parsed
//   while it waits, and only its final load stalls if the old result is still
//   there
// reset: clears the parser to expect the magic bytes and empties the output
//   register; after each result the parser returns to that state by itself
`default_nettype none
module pgm_ascii_parse_validate_stats #(
  parameter int DIM_BITS   = 16,
  parameter int TOKEN_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,   // data_byte
  input  logic                           s_axis_tlast_i,   // end_of_file
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // status, image_width, image_height, max_value, min_pixel, max_pixel,
  // mean_pixel, pixel_count, zero pad
  output logic [pgm_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  pgm_pkg::dp_cmd_t  cmd;
  pgm_pkg::dp_stat_t stat;

  pgm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pgm_datapath #(
    .DIM_BITS   (DIM_BITS),
    .TOKEN_BITS (TOKEN_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .data_byte_i (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

FILE: sv/pgm_ctrl.sv
`default_nettype none
module pgm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  input  pgm_pkg::dp_stat_t  stat_i,
  output pgm_pkg::dp_cmd_t   cmd_o
);

  pgm_pkg::ctl_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pgm_pkg::CTL_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pgm_pkg::CTL_RUN: begin
        if (in_valid_i && in_last_i) begin
          state_d = pgm_pkg::CTL_TOKEN;
        end
      end
      pgm_pkg::CTL_TOKEN:  state_d = pgm_pkg::CTL_HEADER;
      pgm_pkg::CTL_HEADER: state_d = pgm_pkg::CTL_CHECK;
      pgm_pkg::CTL_CHECK:  state_d = pgm_pkg::CTL_DIVIDE;
      pgm_pkg::CTL_DIVIDE: begin
        if (stat_i.div_last) begin
          state_d = pgm_pkg::CTL_LOAD;
        end
      end
      pgm_pkg::CTL_LOAD: begin
        if (!stat_i.out_full) begin
          state_d = pgm_pkg::CTL_RUN;
        end
      end
      default: state_d = pgm_pkg::CTL_RUN;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pgm_pkg::CTL_RUN: begin
        in_ready_o    = 1'b1;
        cmd_o.byte_en = in_valid_i;
      end
      pgm_pkg::CTL_TOKEN:  cmd_o.end_tok  = 1'b1;
      pgm_pkg::CTL_HEADER: cmd_o.hdr_chk  = 1'b1;
      pgm_pkg::CTL_CHECK:  cmd_o.cnt_chk  = 1'b1;
      pgm_pkg::CTL_DIVIDE: cmd_o.div_step = 1'b1;
      pgm_pkg::CTL_LOAD:   cmd_o.load_out = !stat_i.out_full;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/pgm_datapath.sv
`default_nettype none
module pgm_datapath #(
  parameter int DIM_BITS   = 16,
  parameter int TOKEN_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pgm_pkg::dp_cmd_t                 cmd_i,
  output pgm_pkg::dp_stat_t                stat_o,
  input  logic [pgm_pkg::BYTE_W-1:0]       data_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pgm_pkg::OUT_DATA_W-1:0]   out_data_o
);

  localparam int PixW     = pgm_pkg::PIX_W;
  localparam int CountW   = pgm_pkg::COUNT_W;
  localparam int SumW     = pgm_pkg::SUM_W;
  localparam int SumExtW  = SumW + 1;
  localparam int QuoW     = pgm_pkg::QUO_W;
  localparam int DivCntW  = pgm_pkg::DIV_CNT_W;
  localparam int OutDimW  = pgm_pkg::OUT_DIM_W;
  localparam int OutCntW  = pgm_pkg::OUT_COUNT_W;
  localparam int WideW    = TOKEN_BITS + 4;
  localparam int DimCmpW  = (TOKEN_BITS > DIM_BITS) ? TOKEN_BITS : DIM_BITS;
  localparam int ProdW    = 2 * DIM_BITS;
  localparam int CmpW     = (ProdW > CountW) ? ProdW : CountW;
  localparam logic [DimCmpW-1:0] DimMax = DimCmpW'((64'd1 << DIM_BITS) - 64'd1);

  pgm_pkg::phase_e     phase_q, phase_d;
  pgm_pkg::status_e    err_q, err_d;
  pgm_pkg::tok_flags_t flags_q, flags_d, tc_flags;
  logic [TOKEN_BITS-1:0] mag_q, mag_d, tc_mag, mag_digit;
  logic                  comment_q, comment_d;
  logic [DIM_BITS-1:0]   width_q, width_d, height_q, height_d;
  logic [PixW-1:0]       maxval_q, maxval_d, min_q, min_d, max_q, max_d;
  logic [CountW-1:0]     count_q, count_d;
  logic [SumW-1:0]       sum_q, sum_d;
  logic [ProdW-1:0]      prod_q, prod_d;
  logic [SumW-1:0]       rem_q, rem_d;
  logic [SumExtW-1:0]    dvs_q, dvs_d;
  logic [QuoW-1:0]       quo_q, quo_d;
  logic [DivCntW-1:0]    div_cnt_q, div_cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [pgm_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic                  is_digit, is_space;
  logic [3:0]            digit_val;
  logic [WideW-1:0]      mag_wide;
  logic                  acc_en, acc_ok, acc_nonneg, mag_zero;
  logic                  dim_bad, maxval_over, pix_over;
  logic [PixW-1:0]       pix_val;
  logic [SumExtW-1:0]    sum_add;
  logic                  div_ge;
  logic [QuoW-1:0]       mean_out;
  logic [OutCntW-1:0]    count_out;

  assign is_digit  = (data_byte_i >= pgm_pkg::CHAR_ZERO) && (data_byte_i <= pgm_pkg::CHAR_NINE);
  assign is_space  = (data_byte_i == pgm_pkg::CHAR_SPACE) || (data_byte_i == pgm_pkg::CHAR_TAB) ||
                     (data_byte_i == pgm_pkg::CHAR_LF) || (data_byte_i == pgm_pkg::CHAR_VT) ||
                     (data_byte_i == pgm_pkg::CHAR_FF) || (data_byte_i == pgm_pkg::CHAR_CR);
  assign digit_val = 4'(data_byte_i - pgm_pkg::CHAR_ZERO);

  // saturating decimal shift-in
  assign mag_wide  = (WideW'(mag_q) << 3) + (WideW'(mag_q) << 1) + WideW'(digit_val);
  assign mag_digit = (|mag_wide[WideW-1:TOKEN_BITS]) ? '1 : mag_wide[TOKEN_BITS-1:0];

  always_comb begin
    tc_flags        = flags_q;
    tc_mag          = mag_q;
    tc_flags.active = 1'b1;
    if (!flags_q.active && (data_byte_i == pgm_pkg::CHAR_MINUS)) begin
      tc_flags.neg = 1'b1;
    end else if (!flags_q.active && (data_byte_i == pgm_pkg::CHAR_PLUS)) begin
      tc_flags.neg = 1'b0;
    end else if (is_digit) begin
      if (!flags_q.stop) begin
        tc_flags.digit = 1'b1;
        tc_mag         = mag_digit;
      end
    end else begin
      tc_flags.bad  = 1'b1;
      tc_flags.stop = 1'b1;
    end
  end

  // shared value check
  assign mag_zero    = (mag_q == '0);
  assign acc_nonneg  = acc_ok && (!flags_q.neg || mag_zero);
  assign dim_bad     = !acc_ok || flags_q.neg || mag_zero || (DimCmpW'(mag_q) > DimMax);
  assign maxval_over = mag_q > TOKEN_BITS'(pgm_pkg::MAXVAL_LIMIT);
  assign pix_over    = mag_q > TOKEN_BITS'(maxval_q);
  assign pix_val     = PixW'(mag_q);
  assign sum_add     = SumExtW'(sum_q) + SumExtW'(pix_val);

  assign div_ge    = SumExtW'(rem_q) >= dvs_q;
  assign mean_out  = (((err_q == pgm_pkg::STAT_OK) || (err_q == pgm_pkg::STAT_FLAT)) &&
                      (count_q != '0)) ? quo_q : '0;
  assign count_out = count_q[CountW-1] ? '1 : count_q[OutCntW-1:0];

  always_comb begin
    phase_d     = phase_q;
    err_d       = err_q;
    flags_d     = flags_q;
    mag_d       = mag_q;
    comment_d   = comment_q;
    width_d     = width_q;
    height_d    = height_q;
    maxval_d    = maxval_q;
    min_d       = min_q;
    max_d       = max_q;
    count_d     = count_q;
    sum_d       = sum_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    quo_d       = quo_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    acc_en      = 1'b0;
    acc_ok      = 1'b0;

    if (cmd_i.byte_en && (err_q == pgm_pkg::STAT_OK)) begin
      case (phase_q)
        pgm_pkg::PH_MAGIC_P: begin
          if (data_byte_i == pgm_pkg::CHAR_P) begin
            phase_d = pgm_pkg::PH_MAGIC_2;
          end else begin
            err_d = pgm_pkg::STAT_BAD_MAGIC;
          end
        end
        pgm_pkg::PH_MAGIC_2: begin
          if (data_byte_i == pgm_pkg::CHAR_2) begin
            phase_d = pgm_pkg::PH_WIDTH;
          end else begin
            err_d = pgm_pkg::STAT_BAD_MAGIC;
          end
        end
        default: begin
          if (comment_q) begin
            if (data_byte_i == pgm_pkg::CHAR_LF) begin
              comment_d = 1'b0;
            end
          end else if (data_byte_i == pgm_pkg::CHAR_HASH) begin
            acc_en    = flags_q.active;
            acc_ok    = 1'b1;
            flags_d   = '0;
            mag_d     = '0;
            comment_d = 1'b1;
          end else if (is_space) begin
            acc_en  = flags_q.active;
            acc_ok  = !flags_q.bad && flags_q.digit;
            flags_d = '0;
            mag_d   = '0;
          end else begin
            flags_d = tc_flags;
            mag_d   = tc_mag;
          end
        end
      endcase
    end

    if (cmd_i.end_tok && (err_q == pgm_pkg::STAT_OK) && !comment_q) begin
      acc_en  = flags_q.active;
      acc_ok  = !flags_q.bad && flags_q.digit;
      flags_d = '0;
      mag_d   = '0;
    end

    if (acc_en) begin
      case (phase_q)
        pgm_pkg::PH_WIDTH: begin
          if (dim_bad) begin
            err_d   = pgm_pkg::STAT_BAD_SIZE;
            width_d = '0;
          end else begin
            width_d = DIM_BITS'(mag_q);
            phase_d = pgm_pkg::PH_HEIGHT;
          end
        end
        pgm_pkg::PH_HEIGHT: begin
          if (dim_bad) begin
            err_d    = pgm_pkg::STAT_BAD_SIZE;
            width_d  = '0;
            height_d = '0;
          end else begin
            height_d = DIM_BITS'(mag_q);
            phase_d  = pgm_pkg::PH_MAXVAL;
          end
        end
        pgm_pkg::PH_MAXVAL: begin
          if (!acc_nonneg || maxval_over) begin
            err_d = pgm_pkg::STAT_BAD_MAXVAL;
          end else begin
            maxval_d = pix_val;
            min_d    = pix_val;
            max_d    = '0;
            phase_d  = pgm_pkg::PH_PIXEL;
          end
        end
        pgm_pkg::PH_PIXEL: begin
          if (!acc_nonneg || pix_over) begin
            err_d = pgm_pkg::STAT_BAD_PIXEL;
          end else begin
            if (count_q != '1) begin
              count_d = count_q + 1'b1;
            end
            sum_d = sum_add[SumW] ? '1 : sum_add[SumW-1:0];
            if (pix_val < min_q) begin
              min_d = pix_val;
            end
            if (pix_val > max_q) begin
              max_d = pix_val;
            end
          end
        end
        default: begin
          err_d = err_q;
        end
      endcase
    end

    if (cmd_i.hdr_chk) begin
      prod_d = ProdW'(width_q) * ProdW'(height_q);
      if (err_q == pgm_pkg::STAT_OK) begin
        case (phase_q)
          pgm_pkg::PH_MAGIC_P, pgm_pkg::PH_MAGIC_2: err_d = pgm_pkg::STAT_BAD_MAGIC;
          pgm_pkg::PH_WIDTH, pgm_pkg::PH_HEIGHT: begin
            err_d    = pgm_pkg::STAT_BAD_SIZE;
            width_d  = '0;
            height_d = '0;
          end
          pgm_pkg::PH_MAXVAL: err_d = pgm_pkg::STAT_BAD_MAXVAL;
          default: err_d = err_q;
        endcase
      end
    end

    if (cmd_i.cnt_chk) begin
      if (err_q == pgm_pkg::STAT_OK) begin
        if (CmpW'(count_q) != CmpW'(prod_q)) begin
          err_d = pgm_pkg::STAT_COUNT;
        end else if (max_q == min_q) begin
          err_d = pgm_pkg::STAT_FLAT;
        end
      end
      rem_d     = sum_q;
      dvs_d     = SumExtW'(count_q) << (QuoW - 1);
      quo_d     = '0;
      div_cnt_d = DivCntW'(QuoW - 1);
    end

    if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_d = rem_q - SumW'(dvs_q);
      end
      quo_d     = {quo_q[QuoW-2:0], div_ge};
      dvs_d     = dvs_q >> 1;
      div_cnt_d = div_cnt_q - 1'b1;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = {1'b0, count_out, mean_out, max_q, min_q, maxval_q,
                     OutDimW'(height_q), OutDimW'(width_q), err_q};
      phase_d     = pgm_pkg::PH_MAGIC_P;
      err_d       = pgm_pkg::STAT_OK;
      flags_d     = '0;
      mag_d       = '0;
      comment_d   = 1'b0;
      width_d     = '0;
      height_d    = '0;
      maxval_d    = '0;
      min_d       = '0;
      max_d       = '0;
      count_d     = '0;
      sum_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= pgm_pkg::PH_MAGIC_P;
      err_q       <= pgm_pkg::STAT_OK;
      flags_q     <= '0;
      mag_q       <= '0;
      comment_q   <= 1'b0;
      width_q     <= '0;
      height_q    <= '0;
      maxval_q    <= '0;
      min_q       <= '0;
      max_q       <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      err_q       <= err_d;
      flags_q     <= flags_d;
      mag_q       <= mag_d;
      comment_q   <= comment_d;
      width_q     <= width_d;
      height_q    <= height_d;
      maxval_q    <= maxval_d;
      min_q       <= min_d;
      max_q       <= max_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    rem_q      <= rem_d;
    dvs_q      <= dvs_d;
    quo_q      <= quo_d;
    out_data_q <= out_data_d;
  end

  assign stat_o.div_last = (div_cnt_q == '0);
  assign stat_o.out_full = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;

endmodule
`default_nettype wire

FILE: sv/pgm_checker.sv
`default_nettype none
module pgm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_i,
  input logic                           s_axis_tlast_i,
  input logic                           m_axis_tvalid_i,
  input logic                           m_axis_tready_i,
  input logic [pgm_pkg::OUT_DATA_W-1:0] m_axis_tdata_i
);

  logic [2:0] status;
  logic [8:0] mean;

  assign status = m_axis_tdata_i[2:0];
  assign mean   = m_axis_tdata_i[70:62];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> $stable(m_axis_tdata_i))
    else $error("result payload changed while stalled");

  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_i && s_axis_tlast_i |=> !s_axis_tready_i)
    else $error("byte taken right after end of file");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> status != 3'd7)
    else $error("status code out of range");

  a_mean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && status != pgm_pkg::STAT_OK && status != pgm_pkg::STAT_FLAT
      |-> mean == 9'd0)
    else $error("mean reported on failed file");

endmodule

bind pgm_ascii_parse_validate_stats pgm_checker u_pgm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);
`default_nettype wire
